### src/leb_pkg.sv
// Shared types, constants and key decoding for the line edit buffer.
`timescale 1ns / 1ps
`default_nettype none

package leb_pkg;

  localparam int CAPACITY = 64;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW       = 7;

  localparam logic [7:0] KEY_ESC   = 8'd27;
  localparam logic [7:0] KEY_DEL   = 8'd127;
  localparam logic [7:0] KEY_NL    = 8'd10;
  localparam logic [7:0] KEY_LBR   = 8'h5B;
  localparam logic [7:0] KEY_UP    = 8'h41;
  localparam logic [7:0] KEY_DOWN  = 8'h42;
  localparam logic [7:0] KEY_RIGHT = 8'h43;
  localparam logic [7:0] KEY_LEFT  = 8'h44;
  localparam logic [7:0] KEY_THREE = 8'h33;
  localparam logic [7:0] KEY_TILDE = 8'h7E;
  localparam logic [7:0] PRINT_LO  = 8'd32;
  localparam logic [7:0] PRINT_HI  = 8'd126;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_INSERT, ACT_DELETE, ACT_LEFT,
    ACT_RIGHT, ACT_LINECHAR, ACT_EMPTY, ACT_FULL
  } act_e;

  typedef enum logic [2:0] {
    KIND_NOP, KIND_RIGHT, KIND_LEFT, KIND_NL, KIND_DEL, KIND_DELKEY, KIND_PRINT
  } kind_e;

  typedef enum logic [1:0] {
    CH_ZERO, CH_KEY, CH_MEM
  } char_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_SHIFT, ST_FINISH, ST_READOUT
  } state_e;

  typedef struct packed {
    logic [7:0] key_byte0;
    logic [7:0] key_byte1;
    logic [7:0] key_byte2;
    logic [7:0] key_byte3;
  } key_t;

  typedef struct packed {
    act_e          action;
    logic [7:0]    out_char;
    logic [LW-1:0] cursor_pos;
    logic [LW-1:0] line_length;
    logic          last;
  } result_t;

  typedef struct packed {
    logic      load_key;
    logic      shift_start;
    logic      shift_insert;
    logic      shift_run;
    logic      place;
    logic      cur_inc;
    logic      cur_dec;
    logic      len_dec;
    logic      ro_start;
    logic      ro_next;
    logic      emit;
    act_e      emit_act;
    char_sel_e emit_char;
    logic      emit_last;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  cur_zero;
    logic  cur_lt_len;
    logic  len_zero;
    logic  len_full;
    logic  shift_done;
    logic  out_free;
    logic  ro_last;
  } status_t;

  // Priority: up/down, right, left, newline, DEL, delete key, printable.
  function automatic kind_e decode_key(key_t k);
    logic  esc;
    kind_e kind;
    esc  = (k.key_byte0 == KEY_ESC) && (k.key_byte1 == KEY_LBR);
    kind = KIND_NOP;
    if (esc && (k.key_byte2 == KEY_UP || k.key_byte2 == KEY_DOWN)) begin
      kind = KIND_NOP;
    end else if (esc && k.key_byte2 == KEY_RIGHT) begin
      kind = KIND_RIGHT;
    end else if (esc && k.key_byte2 == KEY_LEFT) begin
      kind = KIND_LEFT;
    end else if (k.key_byte0 == KEY_NL) begin
      kind = KIND_NL;
    end else if (k.key_byte0 == KEY_DEL) begin
      kind = KIND_DEL;
    end else if (esc && k.key_byte2 == KEY_THREE && k.key_byte3 == KEY_TILDE) begin
      kind = KIND_DELKEY;
    end else if (k.key_byte0 >= PRINT_LO && k.key_byte0 <= PRINT_HI) begin
      kind = KIND_PRINT;
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

### src/leb_ctrl.sv
// Sequencing state machine of the line edit buffer.
`timescale 1ns / 1ps
`default_nettype none

module leb_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  leb_pkg::status_t status_i,
  output leb_pkg::cmd_t    cmd_o
);
  import leb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.emit_act  = ACT_NONE;
    cmd_o.emit_char = CH_ZERO;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_key = 1'b1;
          state_d        = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status_i.kind)
          KIND_RIGHT: begin
            if (status_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              if (status_i.cur_lt_len) begin
                cmd_o.cur_inc  = 1'b1;
                cmd_o.emit_act = ACT_RIGHT;
              end
              state_d = ST_IDLE;
            end
          end
          KIND_LEFT: begin
            if (status_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              if (!status_i.cur_zero) begin
                cmd_o.cur_dec  = 1'b1;
                cmd_o.emit_act = ACT_LEFT;
              end
              state_d = ST_IDLE;
            end
          end
          KIND_NL: begin
            if (!status_i.len_zero) begin
              cmd_o.ro_start = 1'b1;
              state_d        = ST_READOUT;
            end else if (status_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_act  = ACT_EMPTY;
              cmd_o.emit_last = 1'b1;
              state_d         = ST_IDLE;
            end
          end
          KIND_DEL: begin
            // after a left step a character always lies at the cursor
            if (!status_i.cur_zero) begin
              if (status_i.out_free) begin
                cmd_o.cur_dec     = 1'b1;
                cmd_o.emit        = 1'b1;
                cmd_o.emit_act    = ACT_LEFT;
                cmd_o.shift_start = 1'b1;
                state_d           = ST_SHIFT;
              end
            end else if (!status_i.len_zero) begin
              cmd_o.shift_start = 1'b1;
              state_d           = ST_SHIFT;
            end else if (status_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              state_d         = ST_IDLE;
            end
          end
          KIND_DELKEY: begin
            if (status_i.cur_lt_len) begin
              cmd_o.shift_start = 1'b1;
              state_d           = ST_SHIFT;
            end else if (status_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              state_d         = ST_IDLE;
            end
          end
          KIND_PRINT: begin
            if (!status_i.len_full) begin
              cmd_o.shift_start  = 1'b1;
              cmd_o.shift_insert = 1'b1;
              state_d            = ST_SHIFT;
            end else if (status_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_act  = ACT_FULL;
              cmd_o.emit_char = CH_KEY;
              cmd_o.emit_last = 1'b1;
              state_d         = ST_IDLE;
            end
          end
          default: begin
            if (status_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              state_d         = ST_IDLE;
            end
          end
        endcase
      end
      ST_SHIFT: begin
        cmd_o.shift_run = 1'b1;
        if (status_i.shift_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          if (status_i.kind == KIND_PRINT) begin
            cmd_o.place     = 1'b1;
            cmd_o.emit_act  = ACT_INSERT;
            cmd_o.emit_char = CH_KEY;
          end else begin
            cmd_o.len_dec  = 1'b1;
            cmd_o.emit_act = ACT_DELETE;
          end
          state_d = ST_IDLE;
        end
      end
      ST_READOUT: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_act  = ACT_LINECHAR;
          cmd_o.emit_char = CH_MEM;
          cmd_o.emit_last = status_i.ro_last;
          if (status_i.ro_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.ro_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/leb_datapath.sv
// Line store, cursor and length registers, shift engine and result register.
`timescale 1ns / 1ps
`default_nettype none

module leb_datapath (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  leb_pkg::key_t     in_data_i,
  input  leb_pkg::cmd_t     cmd_i,
  output leb_pkg::status_t  status_o,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output leb_pkg::result_t  out_data_o
);
  import leb_pkg::*;

  logic [7:0]    mem [CAPACITY];
  logic [7:0]    rd_q;
  key_t          key_q;
  logic [LW-1:0] cursor_q, cursor_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] ptr_q, ptr_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic          insert_q, insert_d;
  logic          wr_pend_q, wr_pend_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic          out_valid_q, out_valid_d;
  result_t       out_q, out_d;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          out_free;
  logic [LW-1:0] ptr_step;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cursor_d = cursor_q;
    if (cmd_i.cur_inc || cmd_i.place) begin
      cursor_d = cursor_q + 7'd1;
    end else if (cmd_i.cur_dec) begin
      cursor_d = cursor_q - 7'd1;
    end
    len_d = len_q;
    if (cmd_i.place) begin
      len_d = len_q + 7'd1;
    end else if (cmd_i.len_dec) begin
      len_d = len_q - 7'd1;
    end
  end

  // shift engine: read source at ptr, write it one place over next cycle
  always_comb begin
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    insert_d  = insert_q;
    wr_pend_d = 1'b0;
    wr_addr_d = wr_addr_q;
    rd_en     = 1'b0;
    rd_addr   = ptr_q[AW-1:0];
    ptr_step  = insert_q ? (ptr_q - 7'd1) : (ptr_q + 7'd1);
    if (cmd_i.shift_start) begin
      insert_d = cmd_i.shift_insert;
      if (cmd_i.shift_insert) begin
        ptr_d = len_q - 7'd1;
        cnt_d = len_q - cursor_d;
      end else begin
        ptr_d = cursor_d + 7'd1;
        cnt_d = len_q - cursor_d - 7'd1;
      end
    end else if (cmd_i.shift_run && cnt_q != '0) begin
      rd_en     = 1'b1;
      rd_addr   = ptr_q[AW-1:0];
      ptr_d     = ptr_step;
      cnt_d     = cnt_q - 7'd1;
      wr_pend_d = 1'b1;
      wr_addr_d = insert_q ? AW'(ptr_q + 7'd1) : AW'(ptr_q - 7'd1);
    end else if (cmd_i.ro_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
      ptr_d   = '0;
    end else if (cmd_i.ro_next) begin
      rd_en   = 1'b1;
      ptr_d   = ptr_q + 7'd1;
      rd_addr = ptr_d[AW-1:0];
    end
  end

  assign mem_we    = cmd_i.place || wr_pend_q;
  assign mem_waddr = cmd_i.place ? cursor_q[AW-1:0] : wr_addr_q;
  assign mem_wdata = cmd_i.place ? key_q.key_byte0 : rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (cmd_i.load_key) begin
      key_q <= in_data_i;
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    out_d.action      = cmd_i.emit_act;
    out_d.cursor_pos  = cursor_d;
    out_d.line_length = len_d;
    out_d.last        = cmd_i.emit_last;
    case (cmd_i.emit_char)
      CH_KEY:  out_d.out_char = key_q.key_byte0;
      CH_MEM:  out_d.out_char = rd_q;
      default: out_d.out_char = 8'd0;
    endcase
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      len_q       <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      insert_q    <= 1'b0;
      wr_pend_q   <= 1'b0;
      wr_addr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q    <= cursor_d;
      len_q       <= len_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      insert_q    <= insert_d;
      wr_pend_q   <= wr_pend_d;
      wr_addr_q   <= wr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    status_o.kind       = decode_key(key_q);
    status_o.cur_zero   = (cursor_q == '0);
    status_o.cur_lt_len = (cursor_q < len_q);
    status_o.len_zero   = (len_q == '0);
    status_o.len_full   = (len_q == LW'(CAPACITY));
    status_o.shift_done = (cnt_q == '0) && !wr_pend_q;
    status_o.out_free   = out_free;
    status_o.ro_last    = (7'(ptr_q + 7'd1) == len_q);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= len_q) else $error("cursor beyond line length");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(CAPACITY)) else $error("line length beyond capacity");

  a_place_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.place |-> !wr_pend_q) else $error("char write collides with shift write");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free) else $error("result overwrites a beat not taken");

endmodule

`default_nettype wire

### src/line_edit_buffer_top.sv
// Top level of the line edit buffer: controller plus datapath.
// Sequence: a cursor move or a refused/unknown key gives its single result
//   from the decode state; an insert or delete walks the tail in the shift
//   state and gives its last result from the finish state; a newline
//   readout gives one result per character of the line.
// Throughput: one key at a time; the next key is taken the cycle after the
//   last result is loaded into the output register.
// Reset: rst_ni asynchronous, active low; clears cursor, length and control.
`timescale 1ns / 1ps
`default_nettype none

module line_edit_buffer_top (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  leb_pkg::key_t     in_data_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output leb_pkg::result_t  out_data_o
);
  import leb_pkg::*;

  // Controller and datapath talk only through these two groups.
  cmd_t    cmd;
  status_t status;

  // The controller acts on the decoded key kind, orders the tail shift in the
  // line store, and emits each result beat once the output slot is free.
  leb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the 64-byte line store (one write, one registered
  // read per cycle), moves one character per cycle during a shift, and
  // owns the output register that parts us from the downstream stall.
  leb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
